/* hdl/wsts_pkg.sv */
// Shared types and constants for the weighted-score task scheduler.
package wsts_pkg;

	localparam int NUM_ATTR   = 7;
	localparam int ATTR_W     = 9;
	localparam int WEIGHT_W   = 12;
	localparam int ID_W       = 32;
	localparam int SCORE_W    = 24;
	localparam int PROD_W     = WEIGHT_W + ATTR_W;
	localparam int ATTRS_W    = NUM_ATTR * ATTR_W;
	localparam int ENTRY_W    = ID_W + 1 + ATTRS_W;
	localparam int ATTR_LSB   = ID_W + 1;
	localparam int FIRST_SUB  = 5;
	localparam logic [ATTR_W-1:0] ATTR_MAX = 9'd256;

	typedef enum logic [2:0] {
		CMD_ENQ_SYSTEM = 3'd0,
		CMD_ENQ_OWNER  = 3'd1,
		CMD_SELECT     = 3'd2,
		CMD_REMOVE     = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef logic [WEIGHT_W-1:0] weight_t;

	// Owner preset attributes, attribute 0 in the lowest bits.
	localparam logic [ATTRS_W-1:0] OWNER_PRESET =
		{9'd51, 9'd26, 9'd0, 9'd218, 9'd230, 9'd205, 9'd256};

	localparam weight_t WEIGHT_RESET [NUM_ATTR] =
		'{12'd640, 12'd384, 12'd333, 12'd205, 12'd154, 12'd461, 12'd307};

endpackage

/* hdl/wsts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wsts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/weighted_score_task_scheduler.sv */
// Throughput: one command at a time; the next is taken the cycle after the result is loaded.
// Select runs every entry through one shared 12x9 multiplier, seven products per entry.
// Remove reads and compacts the task RAM one entry at a time, through a read state and a write state.
// arst_n clears the control state, the entry count and restores the reset weights.
// Task RAM contents are not cleared; only entries below the count are ever read.
module weighted_score_task_scheduler
	import wsts_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// command, task_id, owner_priority, urgency, expected_value, confidence,
	// curiosity, risk, resource_cost
	input  logic [103:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// status, chosen_id, chosen_is_owner, chosen_score, removed_count,
	// pending, entry_count
	output logic [71:0]   m_tdata,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [11:0]   cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_SEL_RD, S_SEL_MUL, S_SEL_CMP, S_RM_RD, S_RM_WR, S_DONE
	} state_t;

	state_t                  state_q;
	weight_t                 weights_q [NUM_ATTR];
	logic [CW-1:0]           count_q, i_q, w_q, removed_q;
	cmd_t                    cmd_q;
	logic [ID_W-1:0]         id_q;
	logic [ATTRS_W-1:0]      attrs_q;
	logic [2:0]              k_q;
	logic [PROD_W-1:0]       prod_q;
	logic                    sub_q;
	logic signed [SCORE_W-1:0] acc_q, best_q;
	logic                    best_owner_q;
	logic [ID_W-1:0]         best_id_q;
	status_t                 status_q;
	logic                    m_tvalid_q;
	logic [71:0]             m_tdata_q;

	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
	logic [ATTRS_W-1:0]      sat_attrs;
	logic [ATTR_W-1:0]       cur_attr;
	logic [PROD_W-1:0]       product;
	logic signed [SCORE_W-1:0] term, final_score;
	logic                    rd_owner, take;

	wsts_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Attributes above 1.0 are saturated as they enter the table.
	always_comb begin
		for (int k = 0; k < NUM_ATTR; k++) begin
			sat_attrs[k*ATTR_W +: ATTR_W] =
				(attrs_q[k*ATTR_W +: ATTR_W] > ATTR_MAX) ? ATTR_MAX
				: attrs_q[k*ATTR_W +: ATTR_W];
		end
	end

	// The shared multiplier and the accumulate step.
	assign cur_attr    = ram_rdata[ATTR_LSB + k_q*ATTR_W +: ATTR_W];
	assign product     = PROD_W'(weights_q[k_q]) * PROD_W'(cur_attr);
	assign term        = sub_q ? -$signed(SCORE_W'(prod_q)) : $signed(SCORE_W'(prod_q));
	assign final_score = acc_q + term;
	assign rd_owner    = ram_rdata[ID_W];
	assign take        = (i_q == '0) || (final_score > best_q) ||
		(final_score == best_q && rd_owner && !best_owner_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {sat_attrs, 1'b0, id_q};
		ram_re    = 1'b0;
		ram_raddr = i_q[AW-1:0];
		if (state_q == S_EXEC && (cmd_q == CMD_ENQ_SYSTEM || cmd_q == CMD_ENQ_OWNER)
			&& count_q != CW'(TABLE_DEPTH)) begin
			ram_we = 1'b1;
			if (cmd_q == CMD_ENQ_OWNER) begin
				ram_wdata = {OWNER_PRESET, 1'b1, id_q};
			end
		end
		if (state_q == S_SEL_RD || state_q == S_RM_RD) begin
			ram_re = 1'b1;
		end
		if (state_q == S_RM_WR && ram_rdata[ID_W-1:0] != id_q) begin
			ram_we    = 1'b1;
			ram_waddr = w_q[AW-1:0];
			ram_wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			m_tvalid_q   <= 1'b0;
			weights_q    <= WEIGHT_RESET;
			cmd_q        <= CMD_CLEAR;
			i_q          <= '0;
			w_q          <= '0;
			removed_q    <= '0;
			k_q          <= '0;
			status_q     <= ST_OK;
			best_owner_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index < 3'(NUM_ATTR)) begin
				weights_q[cfg_index] <= cfg_data;
			end
			// In the done state the result register is handled below.
			if (m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q        <= cmd_t'(s_tdata[2:0]);
						id_q         <= s_tdata[34:3];
						attrs_q      <= s_tdata[97:35];
						i_q          <= '0;
						w_q          <= '0;
						removed_q    <= '0;
						status_q     <= ST_OK;
						best_q       <= '0;
						best_id_q    <= '0;
						best_owner_q <= 1'b0;
						state_q      <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q)
						CMD_ENQ_SYSTEM, CMD_ENQ_OWNER: begin
							state_q <= S_DONE;
							if (count_q == CW'(TABLE_DEPTH)) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						CMD_SELECT: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_SEL_RD;
							end
						end
						CMD_REMOVE: begin
							state_q <= (count_q != '0) ? S_RM_RD : S_DONE;
						end
						CMD_CLEAR: begin
							count_q <= '0;
							state_q <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SEL_RD: begin
					k_q     <= '0;
					acc_q   <= '0;
					state_q <= S_SEL_MUL;
				end
				S_SEL_MUL: begin
					prod_q <= product;
					sub_q  <= (k_q >= 3'(FIRST_SUB));
					if (k_q != '0) begin
						acc_q <= final_score;
					end
					if (k_q == 3'(NUM_ATTR - 1)) begin
						state_q <= S_SEL_CMP;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_SEL_CMP: begin
					if (take) begin
						best_q       <= final_score;
						best_id_q    <= ram_rdata[ID_W-1:0];
						best_owner_q <= rd_owner;
					end
					i_q     <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 == count_q) ? S_DONE : S_SEL_RD;
				end
				S_RM_RD: state_q <= S_RM_WR;
				S_RM_WR: begin
					if (ram_rdata[ID_W-1:0] == id_q) begin
						removed_q <= removed_q + 1'b1;
					end else begin
						w_q <= w_q + 1'b1;
					end
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == count_q) begin
						count_q <= count_q - removed_q
							- CW'(ram_rdata[ID_W-1:0] == id_q);
						state_q <= S_DONE;
					end else begin
						state_q <= S_RM_RD;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, 5'(count_q), (count_q != '0),
							5'(removed_q), best_q, best_owner_q, best_id_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RM_WR |-> w_q <= i_q)
		else $error("remove write index passed read index");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside done state");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[1:0] == ST_EMPTY |-> m_tdata_q[69:65] == 5'd0)
		else $error("empty status with held entries");

endmodule

/* tb/weighted_score_task_scheduler_test.sv */
// Self-checking testbench for the weighted-score task scheduler.
module weighted_score_task_scheduler_test
	import wsts_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int REG_COUNT = 7;

	// Fields from the highest bit down; status sits in the lowest bits.
	typedef struct packed {
		logic [4:0]  entry_count;
		logic        pending;
		logic [4:0]  removed_count;
		logic [23:0] chosen_score;
		logic        chosen_is_owner;
		logic [31:0] chosen_id;
		logic [1:0]  status;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [103:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;

	weighted_score_task_scheduler #(.TABLE_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Scheduler shadow state.
	logic [11:0] weight_q [REG_COUNT];
	logic [31:0] task_ids [$];
	logic        task_owner [$];
	logic [8:0]  task_attr [$][REG_COUNT];

	verdict_t expected_verdicts [$];
	int error_count = 0;
	int verdict_count = 0;
	int select_count = 0;
	int full_count = 0;
	int hold_off = 0;
	bit long_stall_req = 1'b0;
	bit long_stall_seen = 1'b0;
	bit burst_mode = 1'b1;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic logic signed [31:0] score_of(input int slot);
		logic signed [31:0] sum;
		sum = 0;
		for (int k = 0; k < REG_COUNT; k++) begin
			if (k >= FIRST_SUB)
				sum -= $signed({11'd0, weight_q[k] * {12'd0, task_attr[slot][k]}});
			else
				sum += $signed({11'd0, weight_q[k] * {12'd0, task_attr[slot][k]}});
		end
		return sum;
	endfunction

	function automatic verdict_t schedule_command(input logic [103:0] item);
		verdict_t v;
		logic [2:0] cmd;
		logic [31:0] id;
		logic [8:0] a [REG_COUNT];
		logic [4:0] removed;
		int best;
		logic signed [31:0] best_score, s;
		v = '0;
		removed = '0;
		cmd = item[2:0];
		id = item[34:3];
		if (cmd == CMD_ENQ_SYSTEM || cmd == CMD_ENQ_OWNER) begin
			if (task_ids.size() >= DEPTH) begin
				v.status = ST_FULL;
			end else begin
				for (int k = 0; k < REG_COUNT; k++) begin
					if (cmd == CMD_ENQ_OWNER)
						a[k] = OWNER_PRESET[k*9 +: 9];
					else
						a[k] = item[35 + k*9 +: 9] > ATTR_MAX ? ATTR_MAX
							: item[35 + k*9 +: 9];
				end
				task_ids.insert(task_ids.size(), id);
				task_owner.insert(task_owner.size(), cmd == CMD_ENQ_OWNER);
				task_attr.insert(task_attr.size(), a);
			end
		end else if (cmd == CMD_SELECT) begin
			if (task_ids.size() == 0) begin
				v.status = ST_EMPTY;
			end else begin
				best = 0;
				best_score = score_of(0);
				for (int i = 1; i < task_ids.size(); i++) begin
					s = score_of(i);
					if (s > best_score || (s == best_score && task_owner[i] && !task_owner[best])) begin
						best = i;
						best_score = s;
					end
				end
				v.chosen_id = task_ids[best];
				v.chosen_is_owner = task_owner[best];
				v.chosen_score = best_score[23:0];
			end
		end else if (cmd == CMD_REMOVE) begin
			for (int i = task_ids.size() - 1; i >= 0; i--) begin
				if (task_ids[i] == id) begin
					task_ids.delete(i);
					task_owner.delete(i);
					task_attr.delete(i);
					removed++;
				end
			end
		end else if (cmd == CMD_CLEAR) begin
			task_ids.delete();
			task_owner.delete();
			task_attr.delete();
		end
		v.removed_count = removed;
		v.pending = task_ids.size() != 0;
		v.entry_count = 5'(task_ids.size());
		return v;
	endfunction

	task automatic send_command(input logic [2:0] cmd, input logic [31:0] id,
			input logic [62:0] attrs);
		// Burst gaps: random idle cycles between transfers when bursting is on.
		if (burst_mode && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tdata <= {6'd0, attrs, id, cmd};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_verdicts.insert(expected_verdicts.size(),
			schedule_command({6'd0, attrs, id, cmd}));
		if (cmd == CMD_SELECT) select_count++;
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (2 + 9 * DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_weight(input int idx, input logic [11:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		weight_q[idx] = value;
		@(posedge clk);
	endtask

	function automatic logic [62:0] random_attrs(input bit wild);
		logic [62:0] a;
		for (int k = 0; k < REG_COUNT; k++)
			a[k*9 +: 9] = wild ? 9'($urandom) : 9'($urandom_range(0, 256));
		return a;
	endfunction

	task automatic test_directed();
		send_command(CMD_SELECT, 32'h0, '0);
		send_command(CMD_REMOVE, 32'h5, '0);
		send_command(CMD_ENQ_SYSTEM, 32'hFFFF_FFFF, {7{9'd256}});
		send_command(CMD_ENQ_SYSTEM, 32'h0, '0);
		send_command(CMD_ENQ_SYSTEM, 32'h1234, {7{9'h1FF}});
		send_command(CMD_ENQ_OWNER, 32'h77, {7{9'h1FF}});
		send_command(CMD_SELECT, 32'h0, '0);
		send_command(CMD_ENQ_OWNER, 32'h77, '0);
		send_command(CMD_REMOVE, 32'h77, '0);
		send_command(3'd5, 32'h1, '0);
		send_command(3'd6, 32'h2, '0);
		send_command(3'd7, 32'h3, '1);
		send_command(CMD_SELECT, 32'h0, '0);
		// A system task whose score equals an owner task's loses the tie.
		send_command(CMD_CLEAR, 32'h0, '0);
		send_command(CMD_ENQ_SYSTEM, 32'hA, {9'd51, 9'd26, 9'd0, 9'd218, 9'd230, 9'd205,
			9'd256});
		send_command(CMD_ENQ_OWNER, 32'hB, '0);
		send_command(CMD_ENQ_SYSTEM, 32'hC, '0);
		send_command(CMD_ENQ_SYSTEM, 32'hD, '0);
		send_command(CMD_SELECT, 32'h0, '0);
		for (int i = 0; i < DEPTH; i++)
			send_command(CMD_ENQ_SYSTEM, 32'(i), random_attrs(1'b0));
		send_command(CMD_SELECT, 32'h0, '0);
		send_command(CMD_CLEAR, 32'h0, '0);
		go_idle();
	endtask

	task automatic test_random(input int count);
		logic [2:0] cmd;
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35) cmd = CMD_ENQ_SYSTEM;
			else if (r < 50) cmd = CMD_ENQ_OWNER;
			else if (r < 78) cmd = CMD_SELECT;
			else if (r < 92) cmd = CMD_REMOVE;
			else if (r < 96) cmd = CMD_CLEAR;
			else cmd = 3'($urandom_range(5, 7));
			// Small id space so removals hit and duplicates occur.
			send_command(cmd, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 12),
				random_attrs($urandom_range(0, 4) == 0));
			if (task_ids.size() >= DEPTH) full_count++;
		end
	endtask

	task automatic test_weights();
		logic [11:0] pick;
		for (int phase = 0; phase < 4; phase++) begin
			for (int k = 0; k < REG_COUNT; k++) begin
				case (phase)
					0: begin
						pick = 12'hFFF;
					end
					1: begin
						pick = 12'h000;
					end
					default: begin
						pick = 12'($urandom);
					end
				endcase
				write_weight(k, pick);
			end
			test_random(120);
			go_idle();
		end
		for (int k = 0; k < REG_COUNT; k++)
			write_weight(k, WEIGHT_RESET[k]);
	endtask

	task automatic test_backpressure();
		// Receiver stalls while the sender keeps offering commands.
		long_stall_req = ~long_stall_req;
		burst_mode = 1'b0;
		test_random(40);
		burst_mode = 1'b1;
		go_idle();
	endtask

	// Result checker.
	always @(posedge clk) begin
		verdict_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[69:0];
			verdict_count++;
			if (expected_verdicts.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = expected_verdicts.pop_front();
				if (got.status != want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.chosen_id != want.chosen_id)
					report_mismatch("chosen_id", got.chosen_id, want.chosen_id);
				if (got.chosen_is_owner != want.chosen_is_owner)
					report_mismatch("chosen_is_owner", 32'(got.chosen_is_owner),
						32'(want.chosen_is_owner));
				if (got.chosen_score != want.chosen_score)
					report_mismatch("chosen_score", 32'(got.chosen_score),
						32'(want.chosen_score));
				if (got.removed_count != want.removed_count)
					report_mismatch("removed_count", 32'(got.removed_count),
						32'(want.removed_count));
				if (got.pending != want.pending)
					report_mismatch("pending", 32'(got.pending), 32'(want.pending));
				if (got.entry_count != want.entry_count)
					report_mismatch("entry_count", 32'(got.entry_count),
						32'(want.entry_count));
			end
		end
	end

	// Receiver stall pattern, with an occasional long hold-off.
	always @(posedge clk) begin
		int phase;
		if (long_stall_req != long_stall_seen) begin
			long_stall_seen <= long_stall_req;
			hold_off <= 300;
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			phase = $urandom_range(0, 15);
			m_tready <= (phase < 11);
		end
	end

	initial begin
		#20ms;
		$display("weighted_score_task_scheduler_test: done, errors");
		$finish;
	end

	initial begin
		for (int k = 0; k < REG_COUNT; k++)
			weight_q[k] = WEIGHT_RESET[k];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(350);
		go_idle();
		test_weights();
		test_backpressure();
		test_random(60);
		go_idle();
		$display("Covered all commands, saturation, ties, full table, weight extremes;");
		$display("%0d results checked, %0d selects, %0d commands left a full table.",
			verdict_count, select_count, full_count);
		if (error_count == 0)
			$display("weighted_score_task_scheduler_test: done, clean");
		else
			$display("weighted_score_task_scheduler_test: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
hdl/wsts_pkg.sv
hdl/wsts_ram.sv
hdl/weighted_score_task_scheduler.sv
tb/weighted_score_task_scheduler_test.sv
